@@ rtl/led_pattern_priority_engine_unit_assert.svh @@
// Assertion macros shared by the LED pattern priority engine RTL.
`ifndef LED_PATTERN_PRIORITY_ENGINE_UNIT_ASSERT_SVH
`define LED_PATTERN_PRIORITY_ENGINE_UNIT_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define LPPE_ASSERT_ALWAYS(name, expr) \
  name: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("lppe assertion failed");

// A condition that must hold in the same cycle as a trigger.
`define LPPE_ASSERT_IMPLY(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lppe assertion failed");

// A condition that must hold in the cycle after a trigger.
`define LPPE_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lppe assertion failed");

`endif

@@ rtl/lppe_pkg.sv @@
// Shared types, constants and functions of the LED pattern priority engine.
package lppe_pkg;

  localparam int PATTERNS_DEF         = 16;
  localparam int TICKS_PER_SECOND_DEF = 1000;

  localparam int ACT_W   = 3;
  localparam int IDX_W   = 4;
  localparam int PRIO_W  = 8;
  localparam int POL_W   = 3;
  localparam int TSEC_W  = 12;
  localparam int COL_W   = 8;
  localparam int MS_W    = 16;
  localparam int CFG_W   = 5;
  localparam int CFG_IDX_W = 1;

  localparam int TSEC_MAX = 2 ** TSEC_W - 1;
  localparam logic [PRIO_W:0] NO_WINNER_PRIO = 9'd256;

  // (x * 683) >> 11 equals x / 3 for every sum of three 8-bit levels.
  localparam logic [10:0] DIV3_MUL = 11'd683;

  typedef enum logic [ACT_W-1:0] {
    ACT_TICK       = 3'd0,
    ACT_ACTIVATE   = 3'd1,
    ACT_DEACTIVATE = 3'd2,
    ACT_SET_DEAD   = 3'd3,
    ACT_SET_DISP   = 3'd4,
    ACT_SET_ENABLE = 3'd5,
    ACT_LOAD       = 3'd6
  } action_t;

  typedef enum logic [POL_W-1:0] {
    POL_DISP_OFF_ALIVE = 3'd0,
    POL_ALIVE          = 3'd1,
    POL_DEAD_DISP_OFF  = 3'd2,
    POL_ENABLED        = 3'd3,
    POL_DEAD_OR_OFF    = 3'd4,
    POL_ALWAYS         = 3'd5
  } policy_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MONO  = 1'b0,
    REG_COUNT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [COL_W-1:0] r;
    logic [COL_W-1:0] g;
    logic [COL_W-1:0] b;
  } colour_t;

  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [POL_W-1:0]  policy;
    logic [TSEC_W-1:0] timeout_sec;
    colour_t           col;
    logic [MS_W-1:0]   on_ms;
    logic [MS_W-1:0]   off_ms;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;
    logic apply;
    logic scan_init;
    logic scan_eval;
    logic scan_final;
    logic cnt_clear;
    logic cnt_next;
    logic tmo_eval;
    logic act_read;
    logic act_write;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic act_ok;
    logic scan_last;
    logic tmo_last;
    logic expired;
    logic out_busy;
    logic one_fg;
  } status_t;

  function automatic logic may_play(input logic [POL_W-1:0] pol, input colour_t c,
                                    input logic dead, input logic disp_off,
                                    input logic allowed);
    logic ok;
    if (c == '0) begin
      ok = 1'b0;
    end else begin
      case (pol)
        POL_DISP_OFF_ALIVE: ok = !dead && disp_off;
        POL_ALIVE:          ok = !dead;
        POL_DEAD_DISP_OFF:  ok = dead && disp_off;
        POL_ENABLED:        ok = allowed;
        POL_DEAD_OR_OFF:    ok = dead || disp_off;
        POL_ALWAYS:         ok = 1'b1;
        default:            ok = 1'b0;
      endcase
    end
    return ok;
  endfunction

endpackage

@@ rtl/lppe_if.sv @@
// Request and result channel interfaces of the LED pattern priority engine.
interface lppe_req_if;
  logic                             valid;
  logic                             ready;
  logic [lppe_pkg::ACT_W-1:0]       action;
  logic [lppe_pkg::IDX_W-1:0]       pattern_index;
  logic                             flag_value;
  logic [lppe_pkg::PRIO_W-1:0]      priority_req;
  logic [lppe_pkg::POL_W-1:0]       policy;
  logic [lppe_pkg::TSEC_W-1:0]      timeout_sec;
  logic [lppe_pkg::COL_W-1:0]       red;
  logic [lppe_pkg::COL_W-1:0]       green;
  logic [lppe_pkg::COL_W-1:0]       blue;
  logic [lppe_pkg::MS_W-1:0]        on_period_ms;
  logic [lppe_pkg::MS_W-1:0]        off_period_ms;

  modport source(output valid, action, pattern_index, flag_value, priority_req, policy,
                 timeout_sec, red, green, blue, on_period_ms, off_period_ms,
                 input ready);
  modport sink(input valid, action, pattern_index, flag_value, priority_req, policy,
               timeout_sec, red, green, blue, on_period_ms, off_period_ms,
               output ready);
endinterface

interface lppe_res_if;
  logic                        valid;
  logic                        ready;
  logic [lppe_pkg::COL_W-1:0]  red_drive;
  logic [lppe_pkg::COL_W-1:0]  green_drive;
  logic [lppe_pkg::COL_W-1:0]  blue_drive;
  logic [lppe_pkg::COL_W-1:0]  white_drive;
  logic                        lit;

  modport source(output valid, red_drive, green_drive, blue_drive, white_drive, lit,
                 input ready);
  modport sink(input valid, red_drive, green_drive, blue_drive, white_drive, lit,
               output ready);
endinterface

@@ rtl/lppe_ctrl.sv @@
// Sequencing state machine of the LED pattern priority engine.
module lppe_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  lppe_pkg::status_t st,
  output lppe_pkg::cmd_t    cmd
);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_APPLY    = 10'b0000000010,
    S_TMO_RD   = 10'b0000000100,
    S_TMO_EV   = 10'b0000001000,
    S_SCAN_RD  = 10'b0000010000,
    S_SCAN_EV  = 10'b0000100000,
    S_SCAN_FIN = 10'b0001000000,
    S_ACT_RD   = 10'b0010000000,
    S_ACT_WR   = 10'b0100000000,
    S_FINISH   = 10'b1000000000
  } state_t;

  typedef enum logic [1:0] {
    RET_DONE = 2'd0,
    RET_ACT  = 2'd1,
    RET_TMO  = 2'd2
  } ret_t;

  state_t state, state_next;
  ret_t   ret, ret_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret   <= RET_DONE;
    end else begin
      state <= state_next;
      ret   <= ret_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    ret_next   = ret;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        if (st.action == lppe_pkg::ACT_TICK) begin
          cmd.cnt_clear = 1'b1;
          state_next    = S_TMO_RD;
        end else if (st.action == lppe_pkg::ACT_ACTIVATE && st.act_ok) begin
          ret_next   = RET_ACT;
          state_next = S_SCAN_RD;
        end else begin
          ret_next   = RET_DONE;
          state_next = S_SCAN_RD;
        end
      end
      S_TMO_RD: begin
        state_next = S_TMO_EV;
      end
      S_TMO_EV: begin
        cmd.tmo_eval = 1'b1;
        if (st.expired) begin
          ret_next   = RET_TMO;
          state_next = S_SCAN_RD;
        end else if (st.tmo_last) begin
          ret_next   = RET_DONE;
          state_next = S_SCAN_RD;
        end else begin
          cmd.cnt_next = 1'b1;
          state_next   = S_TMO_RD;
        end
      end
      S_SCAN_RD: begin
        cmd.scan_init = 1'b1;
        state_next    = S_SCAN_EV;
      end
      S_SCAN_EV: begin
        cmd.scan_eval = 1'b1;
        if (st.scan_last) begin
          state_next = S_SCAN_FIN;
        end
      end
      S_SCAN_FIN: begin
        cmd.scan_final = 1'b1;
        unique case (ret)
          RET_ACT: state_next = S_ACT_RD;
          RET_TMO: begin
            if (st.tmo_last) begin
              ret_next   = RET_DONE;
              state_next = S_SCAN_RD;
            end else begin
              cmd.cnt_next = 1'b1;
              state_next   = S_TMO_RD;
            end
          end
          default: state_next = S_FINISH;
        endcase
      end
      S_ACT_RD: begin
        cmd.act_read = 1'b1;
        state_next   = S_ACT_WR;
      end
      S_ACT_WR: begin
        cmd.act_write = 1'b1;
        ret_next      = RET_DONE;
        state_next    = S_SCAN_RD;
      end
      S_FINISH: begin
        if (!st.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ rtl/lppe_dpath.sv @@
// Entry table, timers, scan logic and result register of the LED pattern engine.
module lppe_dpath #(
  parameter int PATTERNS         = lppe_pkg::PATTERNS_DEF,
  parameter int TICKS_PER_SECOND = lppe_pkg::TICKS_PER_SECOND_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  lppe_pkg::cmd_t                   cmd,
  output lppe_pkg::status_t                st,
  input  logic [lppe_pkg::ACT_W-1:0]       action,
  input  logic [lppe_pkg::IDX_W-1:0]       pattern_index,
  input  logic                             flag_value,
  input  logic [lppe_pkg::PRIO_W-1:0]      priority_req,
  input  logic [lppe_pkg::POL_W-1:0]       policy,
  input  logic [lppe_pkg::TSEC_W-1:0]      timeout_sec,
  input  logic [lppe_pkg::COL_W-1:0]       red,
  input  logic [lppe_pkg::COL_W-1:0]       green,
  input  logic [lppe_pkg::COL_W-1:0]       blue,
  input  logic [lppe_pkg::MS_W-1:0]        on_period_ms,
  input  logic [lppe_pkg::MS_W-1:0]        off_period_ms,
  input  logic                             cfg_we,
  input  logic [lppe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lppe_pkg::CFG_W-1:0]       cfg_data,
  input  logic                             res_ready,
  output logic                             res_valid,
  output logic [lppe_pkg::COL_W-1:0]       red_drive,
  output logic [lppe_pkg::COL_W-1:0]       green_drive,
  output logic [lppe_pkg::COL_W-1:0]       blue_drive,
  output logic [lppe_pkg::COL_W-1:0]       white_drive,
  output logic                             lit
);

  localparam int IW = (PATTERNS > 1) ? $clog2(PATTERNS) : 1;
  localparam int CW = $clog2(PATTERNS + 1);
  localparam int TW = $clog2(lppe_pkg::TSEC_MAX * TICKS_PER_SECOND + 1);
  localparam int XW = ((IW > lppe_pkg::IDX_W) ? IW : lppe_pkg::IDX_W) + 2;

  // Latched request.
  logic [lppe_pkg::ACT_W-1:0] act;
  logic [lppe_pkg::IDX_W-1:0] idx_in;
  logic                       flag;
  lppe_pkg::entry_t           ld_entry;

  // Per-entry control bits.
  logic [PATTERNS-1:0] active, fg, lamp, run;

  logic          dead, disp_off, allowed, mono;
  logic [CW-1:0] count;

  lppe_pkg::colour_t drive;
  logic [lppe_pkg::MS_W-1:0] blink_rem, blink_on, blink_off;
  logic [IW-1:0]             owner;
  lppe_pkg::colour_t         blink_col;

  logic                        win_valid;
  logic [lppe_pkg::PRIO_W:0]   prio;
  logic [IW-1:0]               win;
  lppe_pkg::colour_t           win_col;
  logic [lppe_pkg::MS_W-1:0]   win_on, win_off;

  logic [IW-1:0] scnt, tcnt;

  lppe_pkg::entry_t set_mem [PATTERNS];
  lppe_pkg::entry_t set_q;
  logic [IW-1:0]    set_raddr;
  logic [TW-1:0]    tmo_mem [PATTERNS];
  logic [TW-1:0]    tmo_q, tmo_wdata, prod;
  logic [IW-1:0]    tmo_waddr;
  logic             tmo_wr;

  logic [IW-1:0] idx_a;
  logic          act_ok, load_ok, is_load, blink_live, expired;
  logic          play, in_rng, beats, run_e;

  logic [9:0]  sum3;
  logic [20:0] prod3;

  assign idx_a   = IW'(idx_in);
  assign act_ok  = XW'(idx_in) < XW'(count);
  assign load_ok = XW'(idx_in) < XW'(PATTERNS);
  assign is_load = cmd.apply && act == lppe_pkg::ACT_LOAD && load_ok;
  assign blink_live = blink_rem != '0;
  assign expired = run[tcnt] && tmo_q == TW'(1);

  assign play   = lppe_pkg::may_play(set_q.policy, set_q.col, dead, disp_off, allowed);
  assign in_rng = XW'(scnt) < XW'(count);
  assign beats  = !(prio < {1'b0, set_q.prio});
  assign run_e  = in_rng && active[scnt] && play && beats;

  assign set_raddr = cmd.act_read ? idx_a : (cmd.scan_init ? '0 : IW'(scnt + 1'b1));
  assign prod      = TW'(32'(set_q.timeout_sec) * 32'(TICKS_PER_SECOND));
  assign tmo_wr    = (cmd.tmo_eval && run[tcnt]) || cmd.act_write;
  assign tmo_waddr = cmd.act_write ? idx_a : tcnt;
  assign tmo_wdata = cmd.act_write ? prod : tmo_q - TW'(1);

  always_ff @(posedge clk) begin
    if (is_load) begin
      set_mem[idx_a] <= ld_entry;
    end
    set_q <= set_mem[set_raddr];
  end

  always_ff @(posedge clk) begin
    if (tmo_wr) begin
      tmo_mem[tmo_waddr] <= tmo_wdata;
    end
    tmo_q <= tmo_mem[tcnt];
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      act                  <= action;
      idx_in               <= pattern_index;
      flag                 <= flag_value;
      ld_entry.prio        <= priority_req;
      ld_entry.policy      <= policy;
      ld_entry.timeout_sec <= timeout_sec;
      ld_entry.col         <= '{r: red, g: green, b: blue};
      ld_entry.on_ms       <= on_period_ms;
      ld_entry.off_ms      <= off_period_ms;
    end
    if (cmd.scan_eval && run_e) begin
      win     <= scnt;
      win_col <= set_q.col;
      win_on  <= set_q.on_ms;
      win_off <= set_q.off_ms;
    end
    if (cmd.scan_final && win_valid && !fg[win] && win_on != '0 && win_off != '0) begin
      owner     <= win;
      blink_col <= win_col;
      blink_on  <= win_on;
      blink_off <= win_off;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= '0;
      fg        <= '0;
      lamp      <= '0;
      run       <= '0;
      dead      <= 1'b0;
      disp_off  <= 1'b0;
      allowed   <= 1'b0;
      mono      <= 1'b0;
      count     <= '0;
      drive     <= '0;
      blink_rem <= '0;
      win_valid <= 1'b0;
      prio      <= lppe_pkg::NO_WINNER_PRIO;
      scnt      <= '0;
      tcnt      <= '0;
      res_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == lppe_pkg::REG_MONO) begin
          mono <= cfg_data[0];
        end else begin
          count <= (XW'(cfg_data) > XW'(PATTERNS)) ? CW'(PATTERNS) : CW'(cfg_data);
        end
      end

      if (cmd.apply) begin
        case (act)
          lppe_pkg::ACT_TICK: begin
            if (blink_live) begin
              if (blink_rem == lppe_pkg::MS_W'(1)) begin
                lamp[owner] <= !lamp[owner];
                if (!lamp[owner]) begin
                  drive     <= blink_col;
                  blink_rem <= blink_on;
                end else begin
                  drive     <= '0;
                  blink_rem <= blink_off;
                end
              end else begin
                blink_rem <= blink_rem - lppe_pkg::MS_W'(1);
              end
            end
          end
          lppe_pkg::ACT_ACTIVATE: begin
            if (act_ok) begin
              active[idx_a] <= 1'b1;
            end
          end
          lppe_pkg::ACT_DEACTIVATE: begin
            if (act_ok) begin
              active[idx_a] <= 1'b0;
              run[idx_a]    <= 1'b0;
            end
          end
          lppe_pkg::ACT_SET_DEAD:   dead     <= flag;
          lppe_pkg::ACT_SET_DISP:   disp_off <= flag;
          lppe_pkg::ACT_SET_ENABLE: allowed  <= flag;
          lppe_pkg::ACT_LOAD: begin
            if (load_ok) begin
              if ((blink_live && owner == idx_a) || fg[idx_a]) begin
                drive <= '0;
              end
              if (blink_live && owner == idx_a) begin
                blink_rem <= '0;
              end
              active[idx_a] <= 1'b0;
              fg[idx_a]     <= 1'b0;
              lamp[idx_a]   <= 1'b0;
              run[idx_a]    <= 1'b0;
            end
          end
          default: ;
        endcase
      end

      if (cmd.scan_init) begin
        win_valid <= 1'b0;
        prio      <= lppe_pkg::NO_WINNER_PRIO;
        scnt      <= '0;
      end

      if (cmd.scan_eval) begin
        scnt <= IW'(scnt + 1'b1);
        if (run_e) begin
          // The earlier winner is pushed back, and its blink stops with it.
          if (win_valid) begin
            if (blink_live && owner == win) begin
              drive     <= '0;
              blink_rem <= '0;
            end
            fg[win] <= 1'b0;
          end
          win_valid <= 1'b1;
          prio      <= {1'b0, set_q.prio};
        end else if (fg[scnt]) begin
          if (blink_live && owner == scnt) begin
            blink_rem <= '0;
          end
          drive      <= '0;
          fg[scnt]   <= 1'b0;
          lamp[scnt] <= 1'b0;
        end
      end

      if (cmd.scan_final && win_valid && !fg[win]) begin
        drive     <= win_col;
        lamp[win] <= 1'b1;
        fg[win]   <= 1'b1;
        if (win_on != '0 && win_off != '0) begin
          blink_rem <= win_on;
        end
      end

      if (cmd.cnt_clear) begin
        tcnt <= '0;
      end else if (cmd.cnt_next) begin
        tcnt <= IW'(tcnt + 1'b1);
      end

      if (cmd.tmo_eval && expired) begin
        drive        <= '0;
        lamp[tcnt]   <= 1'b0;
        active[tcnt] <= 1'b0;
        run[tcnt]    <= 1'b0;
      end

      if (cmd.act_write) begin
        run[idx_a] <= prod != '0;
      end

      if (cmd.out_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  assign sum3  = 10'(drive.r) + 10'(drive.g) + 10'(drive.b);
  assign prod3 = 21'(sum3) * 21'(lppe_pkg::DIV3_MUL);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      red_drive   <= mono ? '0 : drive.r;
      green_drive <= mono ? '0 : drive.g;
      blue_drive  <= mono ? '0 : drive.b;
      white_drive <= mono ? prod3[18:11] : '0;
      lit         <= |(fg & lamp);
    end
  end

  assign st.action    = act;
  assign st.act_ok    = act_ok;
  assign st.scan_last = scnt == IW'(PATTERNS - 1);
  assign st.tmo_last  = tcnt == IW'(PATTERNS - 1);
  assign st.expired   = expired;
  assign st.out_busy  = res_valid && !res_ready;
  assign st.one_fg    = $onehot0(fg);

endmodule

@@ rtl/led_pattern_priority_engine_unit.sv @@
// Top level of the LED pattern priority engine: controller, datapath and checks.
// Every request ends with a scan of the table for the winner; an activate of a live
// entry scans first and arms its timeout, and a tick first steps through all timeouts,
// rescanning for each that runs out. The result waits while the previous is not taken.
// The next request is taken as soon as the result sits in the output register.
// Synchronous reset clears all entries' state, flags, timers and drive levels.
`include "led_pattern_priority_engine_unit_assert.svh"

module led_pattern_priority_engine_unit #(
  parameter int PATTERNS         = lppe_pkg::PATTERNS_DEF,
  parameter int TICKS_PER_SECOND = lppe_pkg::TICKS_PER_SECOND_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  lppe_req_if.sink                       req,
  lppe_res_if.source                     res,
  input  logic                           cfg_we,
  input  logic [lppe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lppe_pkg::CFG_W-1:0]     cfg_data
);

  lppe_pkg::cmd_t    cmd;
  lppe_pkg::status_t st;
  logic              one_cmd;

  lppe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .st       (st),
    .cmd      (cmd)
  );

  lppe_dpath #(
    .PATTERNS         (PATTERNS),
    .TICKS_PER_SECOND (TICKS_PER_SECOND)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .action        (req.action),
    .pattern_index (req.pattern_index),
    .flag_value    (req.flag_value),
    .priority_req  (req.priority_req),
    .policy        (req.policy),
    .timeout_sec   (req.timeout_sec),
    .red           (req.red),
    .green         (req.green),
    .blue          (req.blue),
    .on_period_ms  (req.on_period_ms),
    .off_period_ms (req.off_period_ms),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .res_ready     (res.ready),
    .res_valid     (res.valid),
    .red_drive     (res.red_drive),
    .green_drive   (res.green_drive),
    .blue_drive    (res.blue_drive),
    .white_drive   (res.white_drive),
    .lit           (res.lit)
  );

  assign one_cmd = $onehot0({cmd.apply, cmd.scan_eval, cmd.scan_final, cmd.tmo_eval,
                             cmd.act_write, cmd.out_load});

  `LPPE_ASSERT_NEXT(a_busy_after_request, req.valid && req.ready, !req.ready)
  `LPPE_ASSERT_ALWAYS(a_single_command, one_cmd)
  `LPPE_ASSERT_ALWAYS(a_single_foreground, st.one_fg)
  `LPPE_ASSERT_IMPLY(a_result_slot_free, cmd.out_load, !st.out_busy)

endmodule

@@ sim/led_pattern_priority_engine_unit_tb.sv @@
// Self-checking testbench of the LED pattern priority engine with a request predictor.
`timescale 1ns / 100ps

module led_pattern_priority_engine_unit_tb;

  localparam int NPAT = 16;
  localparam int TICKS = 1000;
  localparam logic [lppe_pkg::ACT_W-1:0] ACT_UNDEF = 3'd7;
  localparam logic [lppe_pkg::POL_W-1:0] POL_BAD6 = 3'd6;
  localparam logic [lppe_pkg::POL_W-1:0] POL_BAD7 = 3'd7;

  typedef struct {
    logic [lppe_pkg::ACT_W-1:0]  action;
    logic [lppe_pkg::IDX_W-1:0]  idx;
    logic                        flag;
    logic [lppe_pkg::PRIO_W-1:0] prio;
    logic [lppe_pkg::POL_W-1:0]  policy;
    logic [lppe_pkg::TSEC_W-1:0] tsec;
    lppe_pkg::colour_t           col;
    logic [lppe_pkg::MS_W-1:0]   on_ms;
    logic [lppe_pkg::MS_W-1:0]   off_ms;
  } request_t;

  typedef struct {
    logic [lppe_pkg::COL_W-1:0] r, g, b, w;
    logic                       lit;
  } drive_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [lppe_pkg::CFG_IDX_W-1:0] cfg_index = lppe_pkg::REG_MONO;
  logic [lppe_pkg::CFG_W-1:0] cfg_data = '0;

  lppe_req_if req_ch();
  lppe_res_if res_ch();

  led_pattern_priority_engine_unit i_dut (
    .clk(clk), .rst(rst), .req(req_ch), .res(res_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state.
  lppe_pkg::entry_t tbl[NPAT];
  bit          act[NPAT], fg[NPAT], lamp[NPAT];
  int unsigned tmo_left[NPAT];
  logic [lppe_pkg::MS_W-1:0] blink_left;
  int          blink_owner;
  bit          dead, disp_off, allowed, mono;
  int          live_count;
  lppe_pkg::colour_t drive_col;

  request_t pending[$];
  drive_t   expected_drive[$];
  int outstanding = 0;
  int errors = 0, n_results = 0, n_lit = 0, n_expired = 0;
  bit quiet = 1'b0;

  function automatic bit entry_plays(int i);
    lppe_pkg::entry_t e;
    e = tbl[i];
    if (e.col == '0) return 1'b0;
    case (e.policy)
      lppe_pkg::POL_DISP_OFF_ALIVE: return !dead && disp_off;
      lppe_pkg::POL_ALIVE:          return !dead;
      lppe_pkg::POL_DEAD_DISP_OFF:  return dead && disp_off;
      lppe_pkg::POL_ENABLED:        return allowed;
      lppe_pkg::POL_DEAD_OR_OFF:    return dead || disp_off;
      lppe_pkg::POL_ALWAYS:         return 1'b1;
      default:                      return 1'b0;
    endcase
  endfunction

  function automatic void end_blink(int i);
    if (blink_left != 0 && blink_owner == i) begin
      drive_col = '0;
      blink_left = '0;
      fg[i] = 1'b0;
    end
  endfunction

  function automatic void pick_winner();
    int win;
    int best;
    bit run;
    win = -1;
    best = int'(lppe_pkg::NO_WINNER_PRIO);
    for (int i = 0; i < NPAT; i++) begin
      // Short circuit keeps inactive entries from being looked at.
      run = i < live_count && act[i];
      if (run) run = entry_plays(i) && !(best < int'(tbl[i].prio));
      if (!run) begin
        if (fg[i]) begin
          end_blink(i);
          drive_col = '0;
          fg[i] = 1'b0;
          lamp[i] = 1'b0;
        end
      end else begin
        if (win >= 0) begin
          end_blink(win);
          fg[win] = 1'b0;
        end
        best = int'(tbl[i].prio);
        win = i;
      end
    end
    if (win >= 0 && !fg[win]) begin
      drive_col = tbl[win].col;
      lamp[win] = 1'b1;
      fg[win] = 1'b1;
      if (tbl[win].on_ms != 0 && tbl[win].off_ms != 0) begin
        blink_left = tbl[win].on_ms;
        blink_owner = win;
      end
    end
  endfunction

  function automatic void advance_ms();
    int o;
    if (blink_left != 0) begin
      blink_left--;
      if (blink_left == 0) begin
        o = blink_owner;
        lamp[o] = !lamp[o];
        drive_col = lamp[o] ? tbl[o].col : '0;
        blink_left = lamp[o] ? tbl[o].on_ms : tbl[o].off_ms;
      end
    end
    for (int i = 0; i < NPAT; i++) begin
      if (tmo_left[i] != 0) begin
        tmo_left[i]--;
        if (tmo_left[i] == 0) begin
          n_expired++;
          drive_col = '0;
          lamp[i] = 1'b0;
          act[i] = 1'b0;
          pick_winner();
        end
      end
    end
  endfunction

  function automatic drive_t predict_drive(request_t q);
    drive_t d;
    int i;
    i = int'(q.idx);
    case (q.action)
      lppe_pkg::ACT_TICK: advance_ms();
      lppe_pkg::ACT_ACTIVATE: if (i < live_count) begin
        act[i] = 1'b1;
        pick_winner();
        tmo_left[i] = int'(tbl[i].timeout_sec) * TICKS;
      end
      lppe_pkg::ACT_DEACTIVATE: if (i < live_count) begin
        act[i] = 1'b0;
        tmo_left[i] = 0;
      end
      lppe_pkg::ACT_SET_DEAD:   dead = q.flag;
      lppe_pkg::ACT_SET_DISP:   disp_off = q.flag;
      lppe_pkg::ACT_SET_ENABLE: allowed = q.flag;
      lppe_pkg::ACT_LOAD: begin
        end_blink(i);
        if (fg[i]) drive_col = '0;
        act[i] = 1'b0;
        fg[i] = 1'b0;
        lamp[i] = 1'b0;
        tmo_left[i] = 0;
        tbl[i].prio = q.prio;
        tbl[i].policy = q.policy;
        tbl[i].timeout_sec = q.tsec;
        tbl[i].col = q.col;
        tbl[i].on_ms = q.on_ms;
        tbl[i].off_ms = q.off_ms;
      end
      default: ;
    endcase
    pick_winner();
    if (mono) begin
      d.r = '0; d.g = '0; d.b = '0;
      d.w = 8'((10'(drive_col.r) + 10'(drive_col.g) + 10'(drive_col.b)) / 10'd3);
    end else begin
      d.r = drive_col.r; d.g = drive_col.g; d.b = drive_col.b; d.w = '0;
    end
    d.lit = 1'b0;
    for (int k = 0; k < NPAT; k++) if (fg[k] && lamp[k]) d.lit = 1'b1;
    return d;
  endfunction

  function automatic request_t blank_req(logic [lppe_pkg::ACT_W-1:0] a, int i, int f);
    request_t q;
    q = '{default: '0};
    q.action = a;
    q.idx = lppe_pkg::IDX_W'(i);
    q.flag = f[0];
    return q;
  endfunction

  function automatic request_t load_req(int i, int p, int pol, int ts, int r, int g, int b,
                                        int on, int off);
    request_t q;
    q = blank_req(lppe_pkg::ACT_LOAD, i, 0);
    q.prio = lppe_pkg::PRIO_W'(p);
    q.policy = lppe_pkg::POL_W'(pol);
    q.tsec = lppe_pkg::TSEC_W'(ts);
    q.col = '{r: lppe_pkg::COL_W'(r), g: lppe_pkg::COL_W'(g), b: lppe_pkg::COL_W'(b)};
    q.on_ms = lppe_pkg::MS_W'(on);
    q.off_ms = lppe_pkg::MS_W'(off);
    return q;
  endfunction

  function automatic request_t random_load(int i);
    request_t q;
    q = blank_req(lppe_pkg::ACT_LOAD, i, int'($urandom_range(1)));
    q.prio = lppe_pkg::PRIO_W'(($urandom_range(3) == 0) ? $urandom : $urandom_range(3));
    q.policy = lppe_pkg::POL_W'(($urandom_range(9) == 0) ? $urandom_range(7)
                                                          : $urandom_range(5));
    q.tsec = lppe_pkg::TSEC_W'(($urandom_range(9) == 0) ? $urandom : $urandom_range(1));
    q.col = 24'($urandom);
    if ($urandom_range(15) == 0) q.col = '0;
    q.on_ms = lppe_pkg::MS_W'(($urandom_range(7) == 0) ? $urandom : $urandom_range(6));
    q.off_ms = lppe_pkg::MS_W'(($urandom_range(7) == 0) ? $urandom : $urandom_range(6));
    return q;
  endfunction

  // Mostly load/activate/tick sequences, with flag changes and noise mixed in.
  task automatic queue_random(int n);
    int k;
    int sel;
    k = 0;
    while (k < n) begin
      sel = int'($urandom_range(99));
      if (sel < 15) begin
        pending.push_back(random_load(int'($urandom_range(15))));
        pending.push_back(blank_req(lppe_pkg::ACT_ACTIVATE, int'($urandom_range(15)), 0));
        k += 2;
      end else if (sel < 25) begin
        pending.push_back(blank_req(lppe_pkg::ACT_ACTIVATE, int'($urandom_range(15)), 0));
        k++;
      end else if (sel < 31) begin
        pending.push_back(blank_req(lppe_pkg::ACT_DEACTIVATE, int'($urandom_range(15)), 0));
        k++;
      end else if (sel < 43) begin
        pending.push_back(blank_req(3'($urandom_range(lppe_pkg::ACT_SET_DEAD,
                                                      lppe_pkg::ACT_SET_ENABLE)),
                                    int'($urandom_range(15)), int'($urandom_range(1))));
        k++;
      end else if (sel < 45) begin
        pending.push_back(blank_req(ACT_UNDEF, int'($urandom_range(15)),
                                    int'($urandom_range(1))));
        k++;
      end else begin
        pending.push_back(blank_req(lppe_pkg::ACT_TICK, int'($urandom_range(15)),
                                    int'($urandom_range(1))));
        k++;
      end
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (pending.size() != 0 || outstanding != 0);
    repeat (80) @(negedge clk);
  endtask

  task automatic write_reg(lppe_pkg::cfg_reg_t which, int value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= which;
    cfg_data <= lppe_pkg::CFG_W'(value);
    if (which == lppe_pkg::REG_MONO) mono = value[0];
    else live_count = (value > NPAT) ? NPAT : value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on result %0d: %s got %0d, expected %0d", n_results, what, got, want);
    errors++;
  endtask

  // Request driver.
  int in_gap = 0;
  request_t on_bus;
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) expected_drive.push_back(predict_drive(on_bus));
      if (!req_ch.valid || req_ch.ready) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          req_ch.valid <= 1'b0;
        end else if (pending.size() != 0) begin
          on_bus = pending.pop_front();
          outstanding++;
          req_ch.valid <= 1'b1;
          req_ch.action <= on_bus.action;
          req_ch.pattern_index <= on_bus.idx;
          req_ch.flag_value <= on_bus.flag;
          req_ch.priority_req <= on_bus.prio;
          req_ch.policy <= on_bus.policy;
          req_ch.timeout_sec <= on_bus.tsec;
          req_ch.red <= on_bus.col.r;
          req_ch.green <= on_bus.col.g;
          req_ch.blue <= on_bus.col.b;
          req_ch.on_period_ms <= on_bus.on_ms;
          req_ch.off_period_ms <= on_bus.off_ms;
          if (!quiet && $urandom_range(9) == 0) in_gap <= int'($urandom_range(1, 12));
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure.
  int out_gap = 0;
  drive_t want;
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (expected_drive.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          want = expected_drive.pop_front();
          if (res_ch.red_drive !== want.r) report_mismatch("red_drive", res_ch.red_drive, want.r);
          if (res_ch.green_drive !== want.g)
            report_mismatch("green_drive", res_ch.green_drive, want.g);
          if (res_ch.blue_drive !== want.b)
            report_mismatch("blue_drive", res_ch.blue_drive, want.b);
          if (res_ch.white_drive !== want.w)
            report_mismatch("white_drive", res_ch.white_drive, want.w);
          if (res_ch.lit !== want.lit) report_mismatch("lit", res_ch.lit, want.lit);
          if (want.lit) n_lit++;
        end
        n_results++;
        outstanding--;
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        res_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(9) == 0) begin
        out_gap <= int'($urandom_range(0, 11));
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    req_ch.valid = 1'b0;
    req_ch.action = lppe_pkg::ACT_TICK;
    req_ch.pattern_index = '0;
    req_ch.flag_value = 1'b0;
    req_ch.priority_req = '0;
    req_ch.policy = lppe_pkg::POL_ALWAYS;
    req_ch.timeout_sec = '0;
    req_ch.red = '0;
    req_ch.green = '0;
    req_ch.blue = '0;
    req_ch.on_period_ms = '0;
    req_ch.off_period_ms = '0;
    res_ch.ready = 1'b0;
    for (int i = 0; i < NPAT; i++) begin
      tbl[i] = '0; act[i] = 0; fg[i] = 0; lamp[i] = 0; tmo_left[i] = 0;
    end
    blink_left = '0; blink_owner = 0;
    dead = 0; disp_off = 0; allowed = 0; mono = 0; live_count = 0;
    drive_col = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Every entry gets loaded first, so a later activate never reads an empty slot.
    pending.push_back(load_req(0, 255, lppe_pkg::POL_ALWAYS, 0, 255, 255, 255, 0, 0));
    pending.push_back(load_req(1, 0, lppe_pkg::POL_DISP_OFF_ALIVE, 4095, 1, 2, 3, 65535,
                               65535));
    pending.push_back(load_req(2, 0, lppe_pkg::POL_ALIVE, 1, 255, 0, 0, 1, 1));
    pending.push_back(load_req(3, 3, lppe_pkg::POL_DEAD_DISP_OFF, 0, 0, 255, 0, 2, 3));
    pending.push_back(load_req(4, 3, lppe_pkg::POL_ENABLED, 0, 0, 0, 255, 0, 5));
    pending.push_back(load_req(5, 2, lppe_pkg::POL_DEAD_OR_OFF, 0, 10, 20, 30, 4, 0));
    pending.push_back(load_req(6, 1, POL_BAD6, 0, 255, 255, 255, 0, 0));
    pending.push_back(load_req(7, 1, POL_BAD7, 0, 255, 255, 255, 0, 0));
    pending.push_back(load_req(8, 0, lppe_pkg::POL_ALWAYS, 0, 0, 0, 0, 0, 0));
    for (int i = 9; i < NPAT; i++) pending.push_back(random_load(i));
    wait_drained();
    write_reg(lppe_pkg::REG_MONO, 0);
    write_reg(lppe_pkg::REG_COUNT, NPAT);

    pending.push_back(blank_req(lppe_pkg::ACT_ACTIVATE, 0, 0));
    pending.push_back(blank_req(lppe_pkg::ACT_ACTIVATE, 2, 0));
    pending.push_back(blank_req(lppe_pkg::ACT_TICK, 0, 0));
    pending.push_back(blank_req(lppe_pkg::ACT_TICK, 0, 0));
    pending.push_back(blank_req(lppe_pkg::ACT_ACTIVATE, 2, 0));
    pending.push_back(blank_req(lppe_pkg::ACT_SET_DEAD, 0, 1));
    pending.push_back(blank_req(lppe_pkg::ACT_SET_DISP, 0, 1));
    pending.push_back(blank_req(lppe_pkg::ACT_SET_ENABLE, 0, 1));
    pending.push_back(blank_req(lppe_pkg::ACT_ACTIVATE, 3, 0));
    pending.push_back(blank_req(lppe_pkg::ACT_ACTIVATE, 6, 0));
    pending.push_back(blank_req(ACT_UNDEF, 15, 1));
    pending.push_back(blank_req(lppe_pkg::ACT_DEACTIVATE, 3, 0));
    pending.push_back(blank_req(lppe_pkg::ACT_LOAD, 0, 0));
    pending.push_back(load_req(0, 255, lppe_pkg::POL_ALWAYS, 0, 255, 255, 255, 0, 0));
    wait_drained();

    // Several settings, extremes included; an entry with a one second timeout runs out.
    for (int ph = 0; ph < 7; ph++) begin
      write_reg(lppe_pkg::REG_MONO, (ph % 2));
      case (ph)
        0: write_reg(lppe_pkg::REG_COUNT, NPAT);
        1: write_reg(lppe_pkg::REG_COUNT, NPAT);
        2: write_reg(lppe_pkg::REG_COUNT, 0);
        3: write_reg(lppe_pkg::REG_COUNT, 5);
        4: write_reg(lppe_pkg::REG_COUNT, 1);
        default: write_reg(lppe_pkg::REG_COUNT, NPAT);
      endcase
      if (ph == 6) quiet = 1'b1;
      if (ph == 1) begin
        pending.push_back(load_req(9, 0, lppe_pkg::POL_ALWAYS, 1, 90, 60, 30, 3, 2));
        pending.push_back(blank_req(lppe_pkg::ACT_ACTIVATE, 9, 0));
        repeat (TICKS + 20) pending.push_back(blank_req(lppe_pkg::ACT_TICK, 0, 0));
      end
      queue_random(80);
      wait_drained();
    end

    $display("checked %0d results, %0d lit, %0d timeouts ran out", n_results, n_lit,
             n_expired);
    $display("covered both colour modes and entry counts 0, 1, 5 and 16");
    if (errors == 0 && expected_drive.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("timeout with %0d requests outstanding", outstanding);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
